/* rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
	else $error("assertion failed");

// Check that a condition implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
	else $error("assertion failed");

`endif

/* rtl/ffpa_pkg.sv */
`timescale 1ns / 1ps
package ffpa_pkg;

	localparam int NUM_PAGES  = 64;
	localparam int PAGE_BYTES = 4096;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int CNT_W      = $clog2(NUM_PAGES + 1);
	localparam int OFF_W      = PAGE_W + PAGE_SHIFT;
	localparam int CFG_W      = 7;
	localparam int FIELD_W    = 32;
	localparam int ALIGN_LOG  = 10;

	localparam int IN_TDATA_W  = 3 * FIELD_W;
	localparam int OUT_TDATA_W = ((OFF_W + 7) / 8) * 8;
	localparam int STATUS_W    = 3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ALIGN = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Decoded request, as handed from the decoder to the sequencer
	typedef struct packed {
		logic                is_free;
		logic                early;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    need;
		logic [PAGE_W-1:0]   amask;
		logic [PAGE_W-1:0]   page;
	} req_t;

endpackage

/* rtl/ffpa_ram.sv */
`timescale 1ns / 1ps
module ffpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ffpa_decode.sv */
`timescale 1ns / 1ps
module ffpa_decode (
	input  logic [ffpa_pkg::IN_TDATA_W-1:0] tdata,
	input  logic                            cmd,
	input  logic [ffpa_pkg::CNT_W-1:0]      limit,
	output ffpa_pkg::req_t                  req
);
	import ffpa_pkg::*;

	logic [FIELD_W-1:0]          size_b;
	logic [FIELD_W-1:0]          align_b;
	logic [FIELD_W-1:0]          off_b;
	logic [FIELD_W:0]            need_sum;
	logic [FIELD_W-PAGE_SHIFT:0] need_full;
	logic                        bad_align;
	logic                        free_bad;

	assign size_b  = tdata[FIELD_W-1:0];
	assign align_b = tdata[2*FIELD_W-1:FIELD_W];
	assign off_b   = tdata[3*FIELD_W-1:2*FIELD_W];

	// Round size up to whole pages
	assign need_sum  = {1'b0, size_b} + (FIELD_W + 1)'(PAGE_BYTES - 1);
	assign need_full = need_sum[FIELD_W:PAGE_SHIFT];

	// Alignment must be zero or a power of two of at least 1 KiB
	assign bad_align = (align_b[ALIGN_LOG-1:0] != '0)
		|| ((align_b & (align_b - FIELD_W'(1))) != '0);

	// Free offset must be page aligned and inside the page range
	assign free_bad = (off_b[PAGE_SHIFT-1:0] != '0) || (off_b[FIELD_W-1:OFF_W] != '0);

	always_comb begin
		req.is_free = (cmd == CMD_FREE);
		req.need    = need_full[CNT_W-1:0];
		req.page    = off_b[OFF_W-1:PAGE_SHIFT];
		// Page index bit i must be zero when alignment is at least 2^(i+1) pages
		for (int i = 0; i < PAGE_W; i++) begin
			req.amask[i] = ((align_b >> (i + PAGE_SHIFT + 1)) != '0);
		end
		req.early  = 1'b0;
		req.status = ST_OK;
		if (cmd == CMD_FREE) begin
			if (free_bad) begin
				req.early  = 1'b1;
				req.status = ST_NOT_FOUND;
			end
		end else if (bad_align) begin
			req.early  = 1'b1;
			req.status = ST_BAD_ALIGN;
		end else if (size_b == '0) begin
			req.early  = 1'b1;
			req.status = ST_ZERO_SIZE;
		end else if (need_full > (FIELD_W - PAGE_SHIFT + 1)'(limit)) begin
			req.early  = 1'b1;
			req.status = ST_NO_SPACE;
		end
	end

endmodule

/* rtl/first_fit_page_allocator.sv */
`timescale 1ns / 1ps
// First-fit page allocator over a heap of NUM_PAGES pages of PAGE_BYTES bytes. A request
// enters on the s_axis channel (tuser 0 allocate, 1 free) and gives one result on m_axis.
// An allocate walks the free map one page per cycle from page 0 with a single run counter,
// scanning at most heap_pages pages (heap_pages capped at NUM_PAGES); rejected requests
// (bad alignment, zero size, oversize, unknown offset) go straight to the result. A free
// reads the run length from the run table and returns one page per cycle. The block
// accepts one request at a time; a result may wait in the output register while the next
// request is being worked, and a finished request holds until that register is taken.
// Writing heap_pages frees all pages at once; no clearing pass follows reset.
module first_fit_page_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: size_bytes [31:0], align_bytes [63:32], free_offset [95:64]
	input  logic [ffpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: cmd
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: alloc_offset [17:0], zero fill above
	output logic [ffpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// tuser: status
	output logic [ffpa_pkg::STATUS_W-1:0]     m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ffpa_pkg::CFG_W-1:0]        cfg_data
);
	import ffpa_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		SCAN,
		FLOAD,
		FSWEEP,
		RESP
	} state_t;

	state_t                state_q;
	logic [CFG_W-1:0]      heap_q;
	logic [NUM_PAGES-1:0]  page_free_q;
	logic [NUM_PAGES-1:0]  run_start_q;
	logic [NUM_PAGES-1:0]  mask_q;
	logic [CNT_W-1:0]      scan_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      need_q;
	logic [PAGE_W-1:0]     amask_q;
	logic [PAGE_W-1:0]     cand_q;
	logic [PAGE_W-1:0]     ptr_q;
	logic [CNT_W-1:0]      len_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [OFF_W-1:0]      res_off_q;
	logic                  m_valid_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic [OFF_W-1:0]      m_off_q;

	logic [CNT_W-1:0]      limit;
	req_t                  req;
	logic                  in_acc;
	logic                  cfg_acc;
	logic [PAGE_W-1:0]     idx;
	logic                  pfree;
	logic                  extend;
	logic [CNT_W-1:0]      cnt_inc;
	logic                  hit;
	logic [PAGE_W-1:0]     cand_next;
	logic [CNT_W-1:0]      rd_len;

	// Saturate the heap size to the page count
	assign limit = (32'(heap_q) > NUM_PAGES) ? CNT_W'(NUM_PAGES) : CNT_W'(heap_q);

	assign cfg_ready     = (state_q == IDLE);
	assign s_axis_tready = (state_q == IDLE) && !cfg_valid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;

	ffpa_decode u_decode (
		.tdata (s_axis_tdata),
		.cmd   (s_axis_tuser),
		.limit (limit),
		.req   (req)
	);

	// Shared scan step: extend or restart the current candidate run
	assign idx       = scan_q[PAGE_W-1:0];
	assign pfree     = page_free_q[idx];
	assign extend    = pfree && ((cnt_q != '0) || ((idx & amask_q) == '0));
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign hit       = (state_q == SCAN) && (scan_q < limit) && extend && (cnt_inc == need_q);
	assign cand_next = (cnt_q == '0) ? idx : cand_q;

	// Run lengths, written on a grant and read on a free
	ffpa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_PAGES)
	) u_run_pages (
		.clk   (clk),
		.we    (hit),
		.waddr (cand_next),
		.wdata (need_q),
		.re    (in_acc),
		.raddr (req.page),
		.rdata (rd_len)
	);

	// Sequencer, page maps and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			heap_q      <= CFG_W'(NUM_PAGES);
			page_free_q <= '1;
			run_start_q <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one loads in its place
			if (m_valid_q && m_axis_tready && (state_q != RESP)) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cfg_acc) begin
						heap_q      <= cfg_data;
						page_free_q <= '1;
						run_start_q <= '0;
					end else if (in_acc) begin
						res_status_q <= req.status;
						res_off_q    <= '0;
						need_q       <= req.need;
						amask_q      <= req.amask;
						scan_q       <= '0;
						cnt_q        <= '0;
						mask_q       <= '0;
						ptr_q        <= req.page;
						if (req.early) begin
							state_q <= RESP;
						end else if (req.is_free) begin
							if (run_start_q[req.page]) begin
								state_q <= FLOAD;
							end else begin
								res_status_q <= ST_NOT_FOUND;
								state_q      <= RESP;
							end
						end else begin
							state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					if (scan_q >= limit) begin
						res_status_q <= ST_NO_SPACE;
						state_q      <= RESP;
					end else if (hit) begin
						page_free_q            <= page_free_q
							& ~(mask_q | (NUM_PAGES'(1) << idx));
						run_start_q[cand_next] <= 1'b1;
						res_status_q           <= ST_OK;
						res_off_q              <= {cand_next, {PAGE_SHIFT{1'b0}}};
						state_q                <= RESP;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
						cand_q <= cand_next;
						if (extend) begin
							cnt_q  <= cnt_inc;
							mask_q <= mask_q | (NUM_PAGES'(1) << idx);
						end else begin
							cnt_q  <= '0;
							mask_q <= '0;
						end
					end
				end
				FLOAD: begin
					run_start_q[ptr_q] <= 1'b0;
					len_q              <= rd_len;
					res_status_q       <= ST_OK;
					state_q            <= (rd_len == '0) ? RESP : FSWEEP;
				end
				FSWEEP: begin
					page_free_q[ptr_q] <= 1'b1;
					len_q              <= len_q - CNT_W'(1);
					ptr_q              <= ptr_q + PAGE_W'(1);
					if (len_q == CNT_W'(1) || ptr_q == PAGE_W'(NUM_PAGES - 1)) begin
						state_q <= RESP;
					end
				end
				RESP: begin
					// Hold until the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q  <= 1'b1;
						m_status_q <= res_status_q;
						m_off_q    <= res_off_q;
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = OUT_TDATA_W'(m_off_q);

endmodule

/* rtl/ffpa_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffpa_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [ffpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                              s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ffpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [ffpa_pkg::STATUS_W-1:0]     m_axis_tuser,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [ffpa_pkg::CFG_W-1:0]        cfg_data
);
	import ffpa_pkg::*;

	// A failed request never carries an offset
	`ASSERT_IMPLIES(a_fail_no_offset, clk, arst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0)

	// Status codes stay within the defined set
	`ASSERT_IMPLIES(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tuser <= ST_ZERO_SIZE)

	// One request at a time: no new transaction right after one is taken
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A register write never coincides with a request transaction
	`ASSERT_IMPLIES(a_cfg_excl, clk, arst_n, cfg_valid && cfg_ready, !(s_axis_tvalid && s_axis_tready))

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Tracks the page map, predicts one result per request and checks the results in order
class page_map_scoreboard;
	typedef struct {
		logic [ffpa_pkg::STATUS_W-1:0]    status;
		logic [ffpa_pkg::OUT_TDATA_W-1:0] offset;
	} grant_t;

	grant_t    grants_due[$];
	bit [6:0]  heap_pages;
	bit        page_free[ffpa_pkg::NUM_PAGES];
	bit        run_start[ffpa_pkg::NUM_PAGES];
	bit [6:0]  run_pages[ffpa_pkg::NUM_PAGES];
	int        errors;

	function new();
		errors = 0;
		set_heap(7'd64);
	endfunction

	// Apply a heap size write: every page free, no runs left
	function void set_heap(bit [6:0] pages);
		heap_pages = pages;
		foreach (page_free[p]) begin
			page_free[p] = 1'b1;
			run_start[p] = 1'b0;
			run_pages[p] = '0;
		end
	endfunction

	function int pending();
		return grants_due.size();
	endfunction

	function logic [ffpa_pkg::STATUS_W-1:0] allocate(bit [31:0] size, bit [31:0] align,
			output bit [31:0] offset);
		longint unsigned need;
		longint unsigned bytes;
		int unsigned     limit;
		bit              fits;
		offset = '0;
		limit = (heap_pages > ffpa_pkg::NUM_PAGES) ? ffpa_pkg::NUM_PAGES : heap_pages;
		if (align[9:0] != 10'd0 || (align & (align - 32'd1)) != 32'd0)
			return ffpa_pkg::ST_BAD_ALIGN;
		if (size == 32'd0)
			return ffpa_pkg::ST_ZERO_SIZE;
		bytes = size;
		need = (bytes + ffpa_pkg::PAGE_BYTES - 1) / ffpa_pkg::PAGE_BYTES;
		if (need > limit)
			return ffpa_pkg::ST_NO_SPACE;
		// First fit: lowest aligned page that starts enough free pages
		for (int p = 0; p + need <= limit; p++) begin
			if (align != 32'd0 && ((p * ffpa_pkg::PAGE_BYTES) & (align - 32'd1)) != 0)
				continue;
			fits = 1'b1;
			for (int k = 0; k < need; k++)
				if (!page_free[p + k])
					fits = 1'b0;
			if (!fits)
				continue;
			for (int k = 0; k < need; k++)
				page_free[p + k] = 1'b0;
			run_start[p] = 1'b1;
			run_pages[p] = need[6:0];
			offset = p * ffpa_pkg::PAGE_BYTES;
			return ffpa_pkg::ST_OK;
		end
		return ffpa_pkg::ST_NO_SPACE;
	endfunction

	function logic [ffpa_pkg::STATUS_W-1:0] release_run(bit [31:0] offset);
		int unsigned page;
		if (offset % ffpa_pkg::PAGE_BYTES != 0)
			return ffpa_pkg::ST_NOT_FOUND;
		page = offset / ffpa_pkg::PAGE_BYTES;
		if (page >= ffpa_pkg::NUM_PAGES || !run_start[page])
			return ffpa_pkg::ST_NOT_FOUND;
		for (int k = 0; k < run_pages[page] && page + k < ffpa_pkg::NUM_PAGES; k++)
			page_free[page + k] = 1'b1;
		run_start[page] = 1'b0;
		return ffpa_pkg::ST_OK;
	endfunction

	// Pick the offset of a live run at random; returns 0 when none is live
	function bit pick_live_offset(output bit [31:0] offset);
		int starts[$];
		offset = '0;
		foreach (run_start[p])
			if (run_start[p])
				starts = {starts, p};
		if (starts.size() == 0)
			return 1'b0;
		offset = starts[$urandom_range(0, starts.size() - 1)] * ffpa_pkg::PAGE_BYTES;
		return 1'b1;
	endfunction

	// Note an accepted request transaction and queue its expected result
	function void note_request(logic cmd, bit [31:0] size, bit [31:0] align,
			bit [31:0] free_offset);
		grant_t    due;
		bit [31:0] offset;
		offset = '0;
		if (cmd == ffpa_pkg::CMD_ALLOC)
			due.status = allocate(size, align, offset);
		else
			due.status = release_run(free_offset);
		if (due.status != ffpa_pkg::ST_OK)
			offset = '0;
		due.offset = '0;
		due.offset[17:0] = offset[17:0];
		grants_due = {grants_due, due};
	endfunction

	task report(string msg);
		$display("tb: mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// Compare a result transaction with the oldest expectation
	task check_result(logic [ffpa_pkg::STATUS_W-1:0] status,
			logic [ffpa_pkg::OUT_TDATA_W-1:0] offset);
		grant_t due;
		if (grants_due.size() == 0) begin
			report($sformatf("result status %0d offset 0x%0h with no request waiting",
				status, offset));
		end else begin
			due = grants_due.pop_front();
			if (status !== due.status)
				report($sformatf("status %0d, expected %0d", status, due.status));
			if (offset !== due.offset)
				report($sformatf("offset 0x%0h, expected 0x%0h", offset, due.offset));
		end
	endtask

	task check_drained();
		if (grants_due.size() != 0)
			report($sformatf("%0d results never arrived", grants_due.size()));
	endtask
endclass

module testbench;
	import ffpa_pkg::*;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int SETTLE_CYCLES = NUM_PAGES + 8;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = CMD_ALLOC;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data = '0;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	page_map_scoreboard sb = new();

	first_fit_page_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the result side at the rate of the current phase
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	task set_idle_mode(idle_mode_t mode);
		tx_idle_pct  = (mode == IDLE_SENDER)   ? 87 : (mode == IDLE_BOTH) ? 19 : 0;
		rx_stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 19 : 0;
	endtask

	// Present one request and hold it until the transaction completes
	task send_request(logic cmd, bit [31:0] size, bit [31:0] align, bit [31:0] free_offset);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {free_offset, align, size};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(cmd, size, align, free_offset);
	endtask

	// Drop valid and wait until every expected result has come
	task drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Write the heap size once the block is idle
	task write_heap(bit [6:0] pages);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= pages;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_heap(pages);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed allocate and free traffic, with some noise
	task random_request();
		int        pick;
		int        shape;
		bit [31:0] size;
		bit [31:0] align;
		bit [31:0] offset;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			shape = $urandom_range(0, 99);
			if (shape < 70)
				size = ($urandom_range(1, 8) - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
			else if (shape < 85)
				size = $urandom_range(1, NUM_PAGES * PAGE_BYTES + 100);
			else if (shape < 95)
				size = $urandom;
			else
				size = '0;
			shape = $urandom_range(0, 99);
			if (shape < 60)
				align = '0;
			else if (shape < 85)
				align = 32'd1 << $urandom_range(10, 18);
			else if (shape < 90)
				align = 32'd1 << $urandom_range(19, 31);
			else
				align = $urandom;
			send_request(CMD_ALLOC, size, align, $urandom);
		end else begin
			if (pick < 88) begin
				if (!sb.pick_live_offset(offset))
					offset = $urandom_range(0, NUM_PAGES - 1) * PAGE_BYTES;
			end else if (pick < 94) begin
				offset = $urandom_range(0, 2 * NUM_PAGES) * PAGE_BYTES;
			end else begin
				offset = $urandom;
			end
			send_request(CMD_FREE, $urandom, $urandom, offset);
		end
	endtask

	initial begin
		int         heap_plan[PHASES] = '{127, 1, 0, 20, 64, 5, -1, -1};
		idle_mode_t idle_plan[PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
			IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

		// Hold reset, then release it away from the clock edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed checks on the reset heap of 64 pages
		set_idle_mode(IDLE_NONE);
		write_heap(7'd64);
		send_request(CMD_ALLOC, 32'd0, 32'd0, $urandom);
		send_request(CMD_ALLOC, 32'd1, 32'd3, $urandom);
		send_request(CMD_ALLOC, 32'd0, 32'd512, $urandom);
		send_request(CMD_ALLOC, 32'd0, 32'd1024, $urandom);
		send_request(CMD_ALLOC, PAGE_BYTES, 32'd0, $urandom);
		send_request(CMD_ALLOC, PAGE_BYTES + 1, 32'd0, $urandom);
		send_request(CMD_ALLOC, 32'd1, 32'd32768, $urandom);
		send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, $urandom);
		send_request(CMD_ALLOC, NUM_PAGES * PAGE_BYTES, 32'd0, $urandom);
		send_request(CMD_ALLOC, 32'd1, 32'h8000_0000, $urandom);
		send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
		send_request(CMD_FREE, $urandom, $urandom, PAGE_BYTES);
		send_request(CMD_FREE, $urandom, $urandom, PAGE_BYTES);
		send_request(CMD_FREE, $urandom, $urandom, 32'd100);
		send_request(CMD_FREE, $urandom, $urandom, 32'hFFFF_F000);
		send_request(CMD_FREE, $urandom, $urandom, NUM_PAGES * PAGE_BYTES);
		send_request(CMD_FREE, $urandom, $urandom, 32'd0);
		send_request(CMD_FREE, $urandom, $urandom, 32'd32768);
		send_request(CMD_ALLOC, NUM_PAGES * PAGE_BYTES, 32'd0, $urandom);
		send_request(CMD_ALLOC, 32'd1, 32'd0, $urandom);
		send_request(CMD_FREE, $urandom, $urandom, 32'd0);
		send_request(CMD_ALLOC, (NUM_PAGES - 1) * PAGE_BYTES + 1, 32'd0, $urandom);
		send_request(CMD_FREE, $urandom, $urandom, 32'hFFFF_FFFF);

		// Random phases, each with its own heap size and idle pattern
		for (int ph = 0; ph < PHASES; ph++) begin
			write_heap(heap_plan[ph] < 0 ? 7'($urandom_range(0, 127)) : 7'(heap_plan[ph]));
			set_idle_mode(idle_plan[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain();
				random_request();
			end
		end

		// Wait out the last results, then give late extras a chance to show
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
